/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/bdq_pkg.sv */
// ---------------------------------------------------------------------------
// bdq_pkg
// Types and constants for the bounded circular deque.
// ---------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int OP_W  = 3;
    localparam int DAT_W = 32;

    localparam logic [OP_W-1:0] OP_QUERY     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_REAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_REAR  = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [DAT_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic                    accepted;
        logic signed [DAT_W-1:0] front_item;
        logic signed [DAT_W-1:0] rear_item;
        logic                    is_empty;
        logic                    is_full;
    } rsp_t;

    typedef struct packed {
        logic shift_right;
        logic shift_left;
        logic load_val;
    } cell_ctl_t;

endpackage

/* src/bdq_cell.sv */
// ---------------------------------------------------------------------------
// bdq_cell
// One storage cell of the shifting deque row.
// ---------------------------------------------------------------------------
module bdq_cell (
    input  logic                            clk,
    input  bdq_pkg::cell_ctl_t              ctl,
    input  logic signed [bdq_pkg::DAT_W-1:0] left_data,
    input  logic signed [bdq_pkg::DAT_W-1:0] right_data,
    input  logic signed [bdq_pkg::DAT_W-1:0] load_data,
    output logic signed [bdq_pkg::DAT_W-1:0] data
);
    import bdq_pkg::*;

    logic signed [DAT_W-1:0] data_reg;
    logic signed [DAT_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_right)
        begin
            data_next = left_data;
        end
        else if (ctl.shift_left)
        begin
            data_next = right_data;
        end
        else if (ctl.load_val)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* src/bounded_circular_deque_top.sv */
// ---------------------------------------------------------------------------
// bounded_circular_deque_top
// Bounded deque of signed 32-bit items held in a row of shifting cells.
//
// Channel   Signals                       Handshake
// request   start, busy, req              taken when start && !busy
// result    rsp_valid, rsp                one-cycle strobe, no backpressure
// config    cfg_wr_en, cfg_wr_data        written when cfg_wr_en
//
// One request per clock; busy stays low. The result appears in the cycle after
// the request, from the output register loaded with the cell row.
// Front is cell 0; insert front shifts the row right, delete front shifts it
// left, rear is read through a DEPTH-way mux at count-1 (count-2 on delete rear).
// Reset clears count and sets capacity to 16; cell contents are not reset.
// ---------------------------------------------------------------------------
module bounded_circular_deque_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bdq_pkg::req_t             req,
    output logic                      rsp_valid,
    output bdq_pkg::rsp_t             rsp,
    input  logic                      cfg_wr_en,
    input  logic [bdq_pkg::CAP_W-1:0] cfg_wr_data
);
    import bdq_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CAP_W-1:0] cap_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic signed [DAT_W-1:0] cell_data [DEPTH];
    cell_ctl_t               cell_ctl  [DEPTH];

    logic [CMP_W-1:0] cap_eff;
    logic             full_now;
    logic             empty_now;
    logic             acc;
    logic             ok;
    logic             ins_front_ok;
    logic             ins_rear_ok;
    logic             del_front_ok;
    logic             del_rear_ok;
    logic [IDX_W-1:0] rear_idx;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;
    logic signed [DAT_W-1:0] rear_val;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    assign cap_eff   = (CMP_W'(cap_reg) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_reg);
    assign full_now  = CMP_W'(cnt_reg) >= cap_eff;
    assign empty_now = (cnt_reg == '0);

    assign ins_front_ok = acc && (req.op == OP_INS_FRONT) && !full_now;
    assign ins_rear_ok  = acc && (req.op == OP_INS_REAR)  && !full_now;
    assign del_front_ok = acc && (req.op == OP_DEL_FRONT) && !empty_now;
    assign del_rear_ok  = acc && (req.op == OP_DEL_REAR)  && !empty_now;

    always_comb
    begin
        case (req.op)
            OP_QUERY:     ok = 1'b1;
            OP_INS_FRONT: ok = !full_now;
            OP_INS_REAR:  ok = !full_now;
            OP_DEL_FRONT: ok = !empty_now;
            OP_DEL_REAR:  ok = !empty_now;
            default:      ok = 1'b0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ins_front_ok || ins_rear_ok)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (del_front_ok || del_rear_ok)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DAT_W-1:0] left_d;
        logic signed [DAT_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = req.item_value;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end

        assign cell_ctl[i].shift_right = ins_front_ok;
        assign cell_ctl[i].shift_left  = del_front_ok;
        assign cell_ctl[i].load_val    = ins_rear_ok && (cnt_reg == CNT_W'(i));

        bdq_cell u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .left_data  (left_d),
            .right_data (right_d),
            .load_data  (req.item_value),
            .data       (cell_data[i])
        );
    end

    // rear item after the step, taken from the row before it moves
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);
    assign rear_idx = del_rear_ok ? cnt_m2[IDX_W-1:0] : cnt_m1[IDX_W-1:0];

    always_comb
    begin
        if (ins_rear_ok || (ins_front_ok && empty_now))
        begin
            rear_val = req.item_value;
        end
        else
        begin
            rear_val = cell_data[rear_idx];
        end
    end

    always_comb
    begin
        rsp_next.accepted = ok;
        rsp_next.is_empty = (cnt_next == '0);
        rsp_next.is_full  = CMP_W'(cnt_next) >= cap_eff;
        if (cnt_next == '0)
        begin
            rsp_next.front_item = '1;
            rsp_next.rear_item  = '1;
        end
        else
        begin
            if (ins_front_ok || (ins_rear_ok && empty_now))
            begin
                rsp_next.front_item = req.item_value;
            end
            else if (del_front_ok)
            begin
                rsp_next.front_item = cell_data[1];
            end
            else
            begin
                rsp_next.front_item = cell_data[0];
            end
            rsp_next.rear_item = rear_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                cnt_reg <= cnt_next;
            end
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            rsp_valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* src/bdq_checker.sv */
// ---------------------------------------------------------------------------
// bdq_checker
// Port-level checks for the bounded circular deque.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdq_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input bdq_pkg::req_t             req,
    input logic                      rsp_valid,
    input bdq_pkg::rsp_t             rsp,
    input logic                      cfg_wr_en,
    input logic [bdq_pkg::CAP_W-1:0] cfg_wr_data
);
    import bdq_pkg::*;

    logic req_taken;
    logic cfg_seen;

    assign req_taken = start && !busy;
    assign cfg_seen  = cfg_wr_en || (cfg_wr_data != cfg_wr_data);

    `ASSERT_NEXT(a_one_result_per_request, clk, rst_n, req_taken, rsp_valid)
    `ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !req_taken, !rsp_valid)
    `ASSERT_IMPLIES(a_empty_reads_minus_one, clk, rst_n, rsp_valid && rsp.is_empty,
        (rsp.front_item == -32'sd1) && (rsp.rear_item == -32'sd1))
    `ASSERT_IMPLIES(a_insert_leaves_items, clk, rst_n,
        rsp_valid && rsp.accepted &&
        (($past(req.op) == OP_INS_FRONT) || ($past(req.op) == OP_INS_REAR)),
        !rsp.is_empty || cfg_seen)
    `ASSERT_IMPLIES(a_query_accepted, clk, rst_n,
        rsp_valid && ($past(req.op) == OP_QUERY), rsp.accepted)

endmodule

bind bounded_circular_deque_top bdq_checker u_bdq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
);
